### rtl/core/atrft_pkg.sv
// Shared constants and the command type passed from the front end to the back end.
package atrft_pkg;

    // Default longest token held in the token store
    localparam int MAX_TOKEN_LEN_DEF = 32;
    // Upper bound of the token length setting; fixes the command field widths
    localparam int MAX_TOKEN_LEN_HI = 63;
    localparam int TOK_LEN_W = $clog2(MAX_TOKEN_LEN_HI + 1);
    // Default depth of the command queue between front and back end
    localparam int CMD_DEPTH_DEF = 4;

    // One command covers everything one input item causes: at most one store
    // write, then a stored token, then up to two empty tokens.
    typedef struct packed {
        logic                 wr_en;
        logic [TOK_LEN_W-1:0] wr_addr;
        logic [7:0]           wr_data;
        logic [TOK_LEN_W-1:0] st_len;   // zero: no stored token to drain
        logic                 st_ovf;
        logic [1:0]           n_emp;    // empty tokens after the stored one
        logic                 line_end;
    } cmd_t;

endpackage

### rtl/core/atrft_if.sv
// Valid/ready channel interfaces for response characters and token items.
interface atrft_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, output char_in, output is_last, input ready);
    modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface atrft_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] token_byte;
    logic       byte_valid;
    logic       token_last;
    logic       truncated;
    logic       line_end;

    modport source (output valid, output token_byte, output byte_valid, output token_last,
                    output truncated, output line_end, input ready);
    modport sink   (input valid, input token_byte, input byte_valid, input token_last,
                    input truncated, input line_end, output ready);
endinterface

### rtl/core/atrft_front.sv
// Front end: parses one character per item and issues store and drain commands.
module atrft_front #(
    parameter int MAX_TOKEN_LEN = atrft_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    atrft_in_if.sink        chars,
    output atrft_pkg::cmd_t cmd,
    output logic            cmd_push,
    input  logic            cmd_full
);
    import atrft_pkg::*;

    localparam int TLEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_TOKEN_LEN);

    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_SKIP   = 4'b0100,
        PH_FIELD  = 4'b1000
    } phase_t;

    typedef enum logic [5:0] {
        K_NONE      = 6'b000001,
        K_RAW       = 6'b000010,
        K_STR       = 6'b000100,
        K_STR_FIN   = 6'b001000,
        K_PAREN     = 6'b010000,
        K_PAREN_FIN = 6'b100000
    } kind_t;

    typedef struct packed {
        logic [TLEN_W-1:0] ln;
        logic              ov;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [TLEN_W-1:0] st_len;
        logic              st_ovf;
        logic [1:0]        n_emp;
    } work_t;

    phase_t            phase_reg, phase_next;
    logic              list_reg, list_next;
    kind_t             kind_reg, kind_next;
    logic [TLEN_W-1:0] len_reg;
    logic              ovf_reg;
    work_t             w;
    logic              accept;
    logic              fin;
    logic [7:0]        c;
    logic              last;

    function automatic work_t f_clear(work_t a);
        work_t r;
        r    = a;
        r.ln = '0;
        r.ov = 1'b0;
        return r;
    endfunction

    function automatic work_t f_append(work_t a, logic [7:0] ch);
        work_t r;
        r = a;
        if (r.ln < TLEN_W'(MAX_TOKEN_LEN))
        begin
            r.wr_en   = 1'b1;
            r.wr_addr = ADDR_W'(r.ln);
            r.wr_data = ch;
            r.ln      = r.ln + TLEN_W'(1);
        end
        else
        begin
            r.ov = 1'b1;
        end
        return r;
    endfunction

    // An empty store sends one empty token, otherwise the stored bytes drain.
    function automatic work_t f_emit(work_t a);
        work_t r;
        r = a;
        if (r.ln == '0)
        begin
            r.n_emp = r.n_emp + 2'd1;
        end
        else
        begin
            r.st_len = r.ln;
            r.st_ovf = r.ov;
        end
        return f_clear(r);
    endfunction

    function automatic work_t f_end_fields(work_t a, kind_t k);
        work_t r;
        r = a;
        if (k == K_NONE)
        begin
            r = f_emit(f_clear(r));
        end
        else if (k == K_RAW)
        begin
            r = f_emit(r);
        end
        return r;
    endfunction

    function automatic logic is_ws(logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= 8'h09) && (ch <= 8'h0D));
    endfunction

    assign chars.ready = !cmd_full;
    assign accept      = chars.valid && chars.ready;
    assign c           = chars.char_in;
    assign last        = chars.is_last;

    always_comb
    begin
        phase_next = phase_reg;
        list_next  = list_reg;
        kind_next  = kind_reg;
        w          = '0;
        w.ln       = len_reg;
        w.ov       = ovf_reg;
        fin        = 1'b0;

        if (phase_next == PH_FIRST)
        begin
            kind_next = K_NONE;
            w         = f_clear(w);
            if (c == CH_LPAREN)
            begin
                list_next  = 1'b1;
                phase_next = PH_SKIP;
                if (last)
                begin
                    w = f_end_fields(w, kind_next);
                end
                fin = 1'b1;
            end
            else
            begin
                list_next  = 1'b0;
                phase_next = PH_PREFIX;
            end
        end

        if (!fin && (phase_next == PH_PREFIX))
        begin
            if (c == CH_COLON)
            begin
                w          = f_clear(w);
                kind_next  = K_NONE;
                phase_next = PH_SKIP;
                if (last)
                begin
                    w = f_end_fields(w, kind_next);
                end
            end
            else
            begin
                w = f_append(w, c);
                if (last)
                begin
                    w = f_emit(w);
                end
            end
            fin = 1'b1;
        end

        if (!fin && (phase_next == PH_SKIP))
        begin
            if (is_ws(c))
            begin
                if (last)
                begin
                    w = f_end_fields(w, kind_next);
                end
                fin = 1'b1;
            end
            else
            begin
                phase_next = PH_FIELD;
                kind_next  = K_NONE;
                w          = f_clear(w);
            end
        end

        if (!fin)
        begin
            // A list line's closing bracket ends a raw or empty field.
            if (list_next && last && (c == CH_RPAREN) &&
                ((kind_next == K_NONE) || (kind_next == K_RAW)))
            begin
                if (kind_next == K_NONE)
                begin
                    w = f_clear(w);
                end
                w = f_emit(w);
            end
            else
            begin
                unique case (kind_next)
                    K_NONE:
                    begin
                        w = f_clear(w);
                        if (c == CH_QUOTE)
                        begin
                            kind_next = K_STR;
                            w         = f_append(w, c);
                        end
                        else if (c == CH_COMMA)
                        begin
                            w = f_emit(w);
                        end
                        else if (c == CH_SPACE)
                        begin
                            kind_next = K_NONE;
                        end
                        else if (c == CH_LPAREN)
                        begin
                            kind_next = K_PAREN;
                            w         = f_append(w, c);
                        end
                        else
                        begin
                            kind_next = K_RAW;
                            w         = f_append(w, c);
                        end
                    end
                    K_RAW:
                    begin
                        if (c == CH_COMMA)
                        begin
                            w         = f_emit(w);
                            kind_next = K_NONE;
                        end
                        else
                        begin
                            w = f_append(w, c);
                        end
                    end
                    K_STR:
                    begin
                        w = f_append(w, c);
                        if (c == CH_QUOTE)
                        begin
                            w         = f_emit(w);
                            kind_next = K_STR_FIN;
                        end
                    end
                    K_PAREN:
                    begin
                        w = f_append(w, c);
                        if (c == CH_RPAREN)
                        begin
                            w         = f_emit(w);
                            kind_next = K_PAREN_FIN;
                        end
                    end
                    K_STR_FIN, K_PAREN_FIN:
                    begin
                        if (c == CH_COMMA)
                        begin
                            kind_next = K_NONE;
                        end
                    end
                    default:
                    begin
                        kind_next = K_NONE;
                        w         = f_clear(w);
                    end
                endcase
                if (last)
                begin
                    w = f_end_fields(w, kind_next);
                end
            end
        end

        if (last)
        begin
            phase_next = PH_FIRST;
            list_next  = 1'b0;
            kind_next  = K_NONE;
            w          = f_clear(w);
        end
    end

    always_comb
    begin
        cmd.wr_en    = w.wr_en;
        cmd.wr_addr  = TOK_LEN_W'(w.wr_addr);
        cmd.wr_data  = w.wr_data;
        cmd.st_len   = TOK_LEN_W'(w.st_len);
        cmd.st_ovf   = w.st_ovf;
        cmd.n_emp    = w.n_emp;
        cmd.line_end = last;
    end

    // Items that neither write nor emit leave nothing for the back end.
    assign cmd_push = accept && (w.wr_en || (w.st_len != '0) || (w.n_emp != 2'd0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
            list_reg  <= 1'b0;
            kind_reg  <= K_NONE;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            list_reg  <= list_next;
            kind_reg  <= kind_next;
            len_reg   <= w.ln;
            ovf_reg   <= w.ov;
        end
    end

    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && chars.is_last |=> (phase_reg == PH_FIRST) && (len_reg == '0))
        else $error("parser did not return to line start after final character");

endmodule

### rtl/core/atrft_cmd_fifo.sv
// Small command queue between the parsing front end and the draining back end.
module atrft_cmd_fifo #(
    parameter int DEPTH = atrft_pkg::CMD_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  atrft_pkg::cmd_t push_data,
    output logic            full,
    input  logic            pop,
    output atrft_pkg::cmd_t pop_data,
    output logic            empty
);
    import atrft_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("command queue read while empty");

endmodule

### rtl/core/atrft_back.sv
// Back end: owns the token store, applies writes and drains tokens byte by byte.
module atrft_back #(
    parameter int MAX_TOKEN_LEN = atrft_pkg::MAX_TOKEN_LEN_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  atrft_pkg::cmd_t cmd,
    input  logic            cmd_empty,
    output logic            cmd_pop,
    atrft_out_if.source     tokens
);
    import atrft_pkg::*;

    localparam int TLEN_W = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_TOKEN_LEN);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SEND  = 4'b0100,
        S_EMPTY = 4'b1000
    } state_t;

    typedef struct packed {
        logic [7:0] token_byte;
        logic       byte_valid;
        logic       token_last;
        logic       truncated;
        logic       line_end;
    } item_t;

    logic [7:0]        store_mem [MAX_TOKEN_LEN];
    logic [7:0]        rd_data_reg;
    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [TLEN_W-1:0] len_reg, len_next;
    logic              ovf_reg, ovf_next;
    logic [1:0]        emp_reg, emp_next;
    logic              le_reg, le_next;
    logic              out_valid_reg, out_valid_next;
    item_t             out_reg, out_next;
    logic              out_free;
    logic              mem_we;
    logic              byte_last;

    assign out_free  = !out_valid_reg || tokens.ready;
    assign byte_last = (TLEN_W'(idx_reg) + TLEN_W'(1)) == len_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        emp_next       = emp_reg;
        le_next        = le_reg;
        out_valid_next = out_valid_reg && !tokens.ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop  = 1'b1;
                    mem_we   = cmd.wr_en;
                    idx_next = '0;
                    len_next = cmd.st_len[TLEN_W-1:0];
                    ovf_next = cmd.st_ovf;
                    emp_next = cmd.n_emp;
                    le_next  = cmd.line_end;
                    if (cmd.st_len != '0)
                    begin
                        state_next = S_READ;
                    end
                    else if (cmd.n_emp != 2'd0)
                    begin
                        state_next = S_EMPTY;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.token_byte = rd_data_reg;
                    out_next.byte_valid = 1'b1;
                    out_next.token_last = byte_last;
                    out_next.truncated  = ovf_reg;
                    out_next.line_end   = le_reg && byte_last && (emp_reg == 2'd0);
                    idx_next            = idx_reg + ADDR_W'(1);
                    if (byte_last)
                    begin
                        state_next = (emp_reg != 2'd0) ? S_EMPTY : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.token_byte = 8'h00;
                    out_next.byte_valid = 1'b0;
                    out_next.token_last = 1'b1;
                    out_next.truncated  = 1'b0;
                    out_next.line_end   = le_reg && (emp_reg == 2'd1);
                    emp_next            = emp_reg - 2'd1;
                    if (emp_reg == 2'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            emp_reg       <= 2'd0;
            le_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            emp_reg       <= emp_next;
            le_reg        <= le_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[cmd.wr_addr[ADDR_W-1:0]] <= cmd.wr_data;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= store_mem[idx_reg];
        end
    end

    assign tokens.valid      = out_valid_reg;
    assign tokens.token_byte = out_reg.token_byte;
    assign tokens.byte_valid = out_reg.byte_valid;
    assign tokens.token_last = out_reg.token_last;
    assign tokens.truncated  = out_reg.truncated;
    assign tokens.line_end   = out_reg.line_end;

    a_send_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEND) || (state_reg == S_READ) |-> TLEN_W'(idx_reg) < len_reg)
        else $error("drain index ran past the stored token length");

    a_empty_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMPTY) |-> (emp_reg != 2'd0))
        else $error("empty token state entered with nothing pending");

endmodule

### rtl/core/at_response_field_tokenizer_top.sv
// Top level of the AT response field tokenizer: front end, command queue, back end.
//
//  Channel   Dir  Payload                                                 Accepted when
//  chars     in   char_in[7:0], is_last                                   valid && ready
//  tokens    out  token_byte[7:0], byte_valid, token_last, truncated,     valid && ready
//                 line_end
//
// The front end takes one character per cycle while the command queue has room.
// The back end takes a command while idle and sends each token byte through a
// registered store read, then the output register load; an empty token is loaded directly.
// Reset clears the parser, the queue pointers and count, and the output valid flag; the token
// store is not cleared, since a byte is always written before it is read.
// A stall on tokens holds the output register and fills the queue; a full
// queue drops chars.ready.
module at_response_field_tokenizer_top #(
    parameter int MAX_TOKEN_LEN = atrft_pkg::MAX_TOKEN_LEN_DEF,
    parameter int CMD_DEPTH     = atrft_pkg::CMD_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    atrft_in_if.sink    chars,
    atrft_out_if.source tokens
);
    import atrft_pkg::*;

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic cmd_push;
    logic cmd_full;
    logic cmd_pop;
    logic cmd_empty;

    // Parse characters, track the current field and issue store/drain commands.
    atrft_front #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .chars    (chars),
        .cmd      (front_cmd),
        .cmd_push (cmd_push),
        .cmd_full (cmd_full)
    );

    // Decouple parsing from draining so each side stalls on its own.
    atrft_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (back_cmd),
        .empty     (cmd_empty)
    );

    // Write token bytes into the store and drain finished tokens as items.
    atrft_back #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .tokens    (tokens)
    );

endmodule
